FILE: hdl/fir_filter_direct_form_defines.svh
// Assertion macros used by the FIR filter RTL.
`ifndef FIR_FILTER_DIRECT_FORM_DEFINES_SVH
`define FIR_FILTER_DIRECT_FORM_DEFINES_SVH

`ifndef SYNTHESIS

`define FIR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define FIR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define FIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FIR_ASSERT(lbl, clk, rst_n, prop, msg)
`define FIR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define FIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hdl/fir_pkg.sv
// Types and constants of the direct-form FIR filter.
package fir_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int FRAC_W      = SAMPLE_W - 1;
    localparam int TAP_INDEX_W = 5;
    localparam int TAP_COUNT_W = 6;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_COEF   = 2'd1,
        OP_CLEAR  = 2'd2
    } fir_op_t;

    typedef struct packed {
        fir_op_t                       operation;
        logic [TAP_INDEX_W-1:0]        tap_index;
        logic signed [SAMPLE_W-1:0]    value;
    } fir_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]    filtered_sample;
        logic                          saturated;
    } fir_out_t;

    // per-cell control for the tap chain
    typedef struct packed {
        logic shift;
        logic clear;
        logic coef_wr;
    } fir_cell_ctrl_t;

endpackage

FILE: hdl/fir_filter_direct_form.sv
// Direct-form FIR filter: tap chain with a partial sum that walks one cell per cycle.
// Sample request: history shift, product settle, partial sum across the tap chain, then round/hold before out_valid;
// the next sample is accepted only after the result is handed out, set mostly by the chain walk, one cell per clock.
// Coefficient write and delay-line clear: no result, accepted back to back when idle.
// Reset (rst_n low, async): coefficients and delay line zero, tap_count = TAPS, no request held.
`include "fir_filter_direct_form_defines.svh"

module fir_filter_direct_form #(
    parameter int TAPS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [fir_pkg::TAP_COUNT_W-1:0]        cfg_wr_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  fir_pkg::fir_in_t                       in_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output fir_pkg::fir_out_t                      out_data
);
    import fir_pkg::*;

    localparam int ACC_W  = 2 * SAMPLE_W + $clog2(TAPS) + 1;
    localparam int CNT_RW = $clog2(TAPS + 1);
    localparam int CNT_W  = (CNT_RW > TAP_COUNT_W) ? CNT_RW : TAP_COUNT_W;

    logic [CNT_W-1:0]           tap_count_reg, tap_count_next;
    logic [CNT_W-1:0]           tap_eff;
    logic                       busy_reg, busy_next;
    logic                       launch1_reg, launch2_reg;
    logic                       out_valid_reg, out_valid_next;
    fir_out_t                   out_data_reg;

    logic                       in_accept;
    logic                       sample_go;
    logic                       coef_go;
    logic                       clear_go;
    logic                       res_valid;
    logic                       res_take;
    fir_out_t                   res;

    logic signed [SAMPLE_W-1:0] hist_chain [TAPS];
    logic signed [ACC_W-1:0]    sum_chain  [TAPS+1];
    logic [TAPS:0]              tok_chain;
    logic [TAPS+2:0]            flight_vec;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = busy_reg;

    always_comb
    begin
        sample_go = 1'b0;
        coef_go   = 1'b0;
        clear_go  = 1'b0;
        case (in_data.operation)
            OP_SAMPLE: sample_go = in_accept;
            OP_COEF:   coef_go   = in_accept;
            OP_CLEAR:  clear_go  = in_accept;
            default:   ;
        endcase
    end

    // active tap count, clamped to 1..TAPS
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            tap_eff = CNT_W'(1);
        end
        else if (tap_count_reg > CNT_W'(TAPS))
        begin
            tap_eff = CNT_W'(TAPS);
        end
        else
        begin
            tap_eff = tap_count_reg;
        end
    end

    assign sum_chain[0] = '0;
    assign tok_chain[0] = launch2_reg;

    for (genvar i = 0; i < TAPS; i++)
    begin : g_tap
        fir_cell_ctrl_t             ctrl;
        logic signed [SAMPLE_W-1:0] sample_in;

        assign ctrl.shift   = sample_go;
        assign ctrl.clear   = clear_go;
        assign ctrl.coef_wr = coef_go && (32'(in_data.tap_index) == 32'(i));

        if (i == 0)
        begin : g_head
            assign sample_in = in_data.value;
        end
        else
        begin : g_body
            assign sample_in = hist_chain[i-1];
        end

        fir_tap_cell #(
            .ACC_W (ACC_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .sample_in  (sample_in),
            .coef_in    (in_data.value),
            .tap_en     (CNT_W'(i) < tap_eff),
            .sum_in     (sum_chain[i]),
            .token_in   (tok_chain[i]),
            .sample_out (hist_chain[i]),
            .sum_out    (sum_chain[i+1]),
            .token_out  (tok_chain[i+1])
        );
    end

    fir_round_sat #(
        .ACC_W (ACC_W)
    ) u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc_valid (tok_chain[TAPS]),
        .acc       (sum_chain[TAPS]),
        .take      (res_take),
        .res_valid (res_valid),
        .res       (res)
    );

    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        tap_count_next = cfg_wr_en ? CNT_W'(cfg_wr_data) : tap_count_reg;

        busy_next = busy_reg;
        if (sample_go)
        begin
            busy_next = 1'b1;
        end
        else if (res_take)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= CNT_W'(TAPS);
            busy_reg      <= 1'b0;
            launch1_reg   <= 1'b0;
            launch2_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tap_count_reg <= tap_count_next;
            busy_reg      <= busy_next;
            // launch1 marks the history shift, launch2 the products settling
            launch1_reg   <= sample_go;
            launch2_reg   <= launch1_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // at most one request anywhere between launch and the result hold stage
    assign flight_vec = {tok_chain, launch1_reg, res_valid};

    `FIR_ASSERT(a_one_in_flight, clk, rst_n, $onehot0(flight_vec), "more than one sample in flight")
    `FIR_ASSERT_IMPL(a_launch_busy, clk, rst_n, launch1_reg || launch2_reg, busy_reg, "launch while idle")
    `FIR_ASSERT_IMPL(a_hold_stalls, clk, rst_n, res_valid, in_stall, "input open while result held")
    `FIR_ASSERT_NEXT(a_sample_launch, clk, rst_n, sample_go, launch1_reg && busy_reg, "sample not launched")
    `FIR_ASSERT_NEXT(a_take_out, clk, rst_n, res_take, out_valid_reg && !busy_reg, "result not handed out")

endmodule

FILE: hdl/fir_tap_cell.sv
// One tap of the FIR chain: delay element, coefficient, multiplier, partial-sum adder.
module fir_tap_cell #(
    parameter int ACC_W = 38
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fir_pkg::fir_cell_ctrl_t             ctrl,
    input  logic signed [fir_pkg::SAMPLE_W-1:0] sample_in,
    input  logic signed [fir_pkg::SAMPLE_W-1:0] coef_in,
    input  logic                                tap_en,
    input  logic signed [ACC_W-1:0]             sum_in,
    input  logic                                token_in,
    output logic signed [fir_pkg::SAMPLE_W-1:0] sample_out,
    output logic signed [ACC_W-1:0]             sum_out,
    output logic                                token_out
);
    import fir_pkg::*;

    logic signed [SAMPLE_W-1:0]   hist_reg, hist_next;
    logic signed [SAMPLE_W-1:0]   coef_reg, coef_next;
    logic signed [2*SAMPLE_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]      sum_reg, sum_next;
    logic                         token_reg;

    always_comb
    begin
        hist_next = hist_reg;
        if (ctrl.clear)
        begin
            hist_next = '0;
        end
        else if (ctrl.shift)
        begin
            hist_next = sample_in;
        end
        coef_next = ctrl.coef_wr ? coef_in : coef_reg;
        prod_next = hist_reg * coef_reg;
        // taps beyond the active count pass the partial sum unchanged
        sum_next  = sum_in + (tap_en ? ACC_W'(prod_reg) : ACC_W'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg  <= '0;
            coef_reg  <= '0;
            token_reg <= 1'b0;
        end
        else
        begin
            hist_reg  <= hist_next;
            coef_reg  <= coef_next;
            token_reg <= token_in;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
    end

    assign sample_out = hist_reg;
    assign sum_out    = sum_reg;
    assign token_out  = token_reg;

endmodule

FILE: hdl/fir_round_sat.sv
// Rounds the accumulated sum to Q1.15, saturates it and holds the result.
module fir_round_sat #(
    parameter int ACC_W = 38
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    acc_valid,
    input  logic signed [ACC_W-1:0] acc,
    input  logic                    take,
    output logic                    res_valid,
    output fir_pkg::fir_out_t       res
);
    import fir_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [ACC_W-1:0] OUT_MAX  = (ACC_W'(1) <<< (SAMPLE_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] OUT_MIN  = -(ACC_W'(1) <<< (SAMPLE_W - 1));

    logic signed [ACC_W-1:0] rounded;
    logic signed [ACC_W-1:0] shifted;
    fir_out_t                res_next;
    logic                    res_valid_reg, res_valid_next;
    fir_out_t                res_reg;

    always_comb
    begin
        // accumulator has a spare top bit, so the half-LSB add cannot wrap
        rounded = acc + HALF_LSB;
        shifted = rounded >>> FRAC_W;
        if (shifted > OUT_MAX)
        begin
            res_next.filtered_sample = OUT_MAX[SAMPLE_W-1:0];
            res_next.saturated       = 1'b1;
        end
        else if (shifted < OUT_MIN)
        begin
            res_next.filtered_sample = OUT_MIN[SAMPLE_W-1:0];
            res_next.saturated       = 1'b1;
        end
        else
        begin
            res_next.filtered_sample = shifted[SAMPLE_W-1:0];
            res_next.saturated       = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (acc_valid)
        begin
            res_valid_next = 1'b1;
        end
        else if (take)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: bench/tb.sv
// Testbench for the direct-form FIR filter: queued requests, filter predictor, output checker.
`timescale 1ns / 1ps

module tb;
    import fir_pkg::*;

    localparam int TAPS = 32;
    localparam int SETTLE_CYCLES = TAPS + 8;
    localparam int HOLD_CYCLES = 400;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASE_ITEMS = 200;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN = -(longint'(1) << (SAMPLE_W - 1));

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [TAP_COUNT_W-1:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    fir_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    fir_out_t out_data;

    fir_in_t pending_requests[$];
    fir_out_t expected_outputs[$];
    logic signed [SAMPLE_W-1:0] coef_mem [TAPS];
    logic signed [SAMPLE_W-1:0] delay_line [TAPS];
    logic [TAP_COUNT_W-1:0] tap_count_reg = TAP_COUNT_W'(TAPS);
    int mismatches = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit hold_req = 1'b0;
    bit steady_flow = 1'b0;

    fir_filter_direct_form #(
        .TAPS(TAPS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void predict_filter(input fir_in_t req);
        longint acc;
        int n;
        fir_out_t res;
        case (req.operation)
            OP_COEF: coef_mem[req.tap_index] = req.value;
            OP_CLEAR:
            begin
                foreach (delay_line[i])
                    delay_line[i] = '0;
            end
            OP_SAMPLE:
            begin
                // whole line shifts, even past the taps in use
                for (int i = TAPS - 1; i > 0; i--)
                    delay_line[i] = delay_line[i - 1];
                delay_line[0] = req.value;
                if (tap_count_reg == 0)
                    n = 1;
                else if (tap_count_reg > TAPS)
                    n = TAPS;
                else
                    n = int'(tap_count_reg);
                acc = 0;
                for (int i = 0; i < n; i++)
                    acc += longint'(coef_mem[i]) * longint'(delay_line[i]);
                // add half an LSB, then floor back to Q1.15
                acc = (acc + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
                res.saturated = (acc > SAMPLE_MAX) || (acc < SAMPLE_MIN);
                if (acc > SAMPLE_MAX)
                    acc = SAMPLE_MAX;
                else if (acc < SAMPLE_MIN)
                    acc = SAMPLE_MIN;
                res.filtered_sample = acc[SAMPLE_W-1:0];
                expected_outputs.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_request(input logic [1:0] op,
                                          input logic [TAP_INDEX_W-1:0] idx,
                                          input logic signed [SAMPLE_W-1:0] val);
        fir_in_t req;
        req.operation = fir_op_t'(op);
        req.tap_index = idx;
        req.value = val;
        pending_requests.push_back(req);
    endfunction

    // narrow values keep most coefficient sets out of saturation
    function automatic logic signed [SAMPLE_W-1:0] pick_value(input bit narrow);
        case ($urandom_range(narrow ? 7 : 3))
            0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1: return SAMPLE_W'($urandom);
            default:
            begin
                if (narrow)
                    return SAMPLE_W'($urandom_range(4095)) - 16'sd2048;
                return SAMPLE_W'($urandom);
            end
        endcase
    endfunction

    function automatic void queue_random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            queue_request(OP_SAMPLE, TAP_INDEX_W'($urandom), pick_value(1'b0));
        else if (pick < 88)
            queue_request(OP_COEF, TAP_INDEX_W'($urandom), pick_value(1'b1));
        else if (pick < 94)
            queue_request(OP_CLEAR, TAP_INDEX_W'($urandom), SAMPLE_W'($urandom));
        else
            queue_request(OP_UNUSED, TAP_INDEX_W'($urandom), SAMPLE_W'($urandom));
    endfunction

    // wait for every request to be taken and every output seen, then let the chain empty
    task automatic settle_idle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_outputs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tap_count(input logic [TAP_COUNT_W-1:0] count);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= count;
        tap_count_reg = count;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                predict_filter(in_data);
            if (!in_valid || !in_stall)
            begin
                if (pending_requests.size() != 0 && (steady_flow || $urandom_range(99) >= 19))
                begin
                    in_data <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted down once requested
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // output monitor and receiver stall
    always @(posedge clk)
    begin
        fir_out_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_outputs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected output filtered_sample %0d saturated %0b",
                                 $realtime, out_data.filtered_sample, out_data.saturated);
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    if (out_data.filtered_sample !== want.filtered_sample
                        || out_data.saturated !== want.saturated)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: output mismatch: expected %0d/%0b, got %0d/%0b",
                                     $realtime, want.filtered_sample, want.saturated,
                                     out_data.filtered_sample, out_data.saturated);
                    end
                end
            end
            out_stall <= (hold_left > 0) || (!steady_flow && $urandom_range(99) < 19);
        end
    end

    initial
    begin
        logic [TAP_COUNT_W-1:0] count;
        foreach (coef_mem[i])
        begin
            coef_mem[i] = '0;
            delay_line[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: all taps in use after reset
        queue_request(OP_SAMPLE, 5'd0, 16'sd0);
        queue_request(OP_COEF, 5'd0, 16'sh7FFF);
        queue_request(OP_COEF, 5'd1, 16'sh7FFF);
        queue_request(OP_SAMPLE, 5'd0, 16'sh7FFF);
        queue_request(OP_SAMPLE, 5'd31, 16'sh7FFF);      // clips high
        queue_request(OP_SAMPLE, 5'd0, 16'sh8000);
        queue_request(OP_COEF, 5'd1, 16'sh8000);
        queue_request(OP_COEF, 5'd0, 16'sh8000);
        queue_request(OP_SAMPLE, 5'd0, 16'sh8000);       // min times min, two taps
        queue_request(OP_SAMPLE, 5'd0, 16'sh7FFF);
        queue_request(OP_SAMPLE, 5'd0, 16'sh7FFF);       // clips low
        queue_request(OP_COEF, 5'd31, 16'shFFFF);
        queue_request(OP_CLEAR, 5'd31, 16'sh7FFF);
        queue_request(OP_COEF, 5'd0, 16'sd1);
        queue_request(OP_COEF, 5'd1, 16'sd0);
        queue_request(OP_SAMPLE, 5'd0, 16'sh4000);       // exactly half an LSB
        queue_request(OP_SAMPLE, 5'd0, -16'sd16384);
        queue_request(OP_SAMPLE, 5'd0, -16'sd16385);
        queue_request(OP_UNUSED, 5'd31, 16'shFFFF);
        queue_request(OP_SAMPLE, 5'd31, 16'sh5555);
        queue_request(OP_COEF, 5'd31, 16'sh7FFF);
        queue_request(OP_SAMPLE, 5'd10, 16'shAAAA);

        for (int p = 0; p < 7; p++)
        begin
            settle_idle();
            case (p)
                0: count = 6'd1;
                1: count = 6'd0;
                2: count = 6'd63;
                3: count = 6'd32;
                4: count = 6'd33;
                default: count = TAP_COUNT_W'($urandom_range(63));
            endcase
            write_tap_count(count);
            steady_flow <= (p == 3);
            repeat (PHASE_ITEMS) queue_random_request();
            if (p == 1)
            begin
                // long receiver hold-off while requests keep coming
                repeat (300) @(posedge clk);
                hold_req <= 1'b1;
            end
        end
        settle_idle();

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
